@@ hdl/point_to_range_direction_top_macros.svh @@
// Assertion macros shared by the point-to-range-direction RTL
`ifndef POINT_TO_RANGE_DIRECTION_TOP_MACROS_SVH
`define POINT_TO_RANGE_DIRECTION_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("prd assertion failed");
// next-cycle implication
`define PRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("prd assertion failed");
`else
`define PRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/prd_pkg.sv @@
// Shared types and constants for the point-to-range-direction block
package prd_pkg;

    localparam int ADDR_W     = 5;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    // sum of the xform, sqrt, divide and output register stages
    localparam int LATENCY    = 58;

    typedef enum logic [2:0] {
        REG_ROT_W     = 3'd0,
        REG_ROT_X     = 3'd1,
        REG_ROT_Y     = 3'd2,
        REG_ROT_Z     = 3'd3,
        REG_SHIFT_X   = 3'd4,
        REG_SHIFT_Y   = 3'd5,
        REG_SHIFT_Z   = 3'd6,
        REG_MAX_RANGE = 3'd7
    } reg_idx_t;

    localparam logic signed [15:0] ROT_W_RESET = 16'sd16384;
    localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
    localparam logic [64:0]        HALF_Q28    = 65'd134217728;
    localparam logic [15:0]        DIR_ONE     = 16'd16384;

    typedef struct packed {
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic [31:0]        max_range;
    } cfg_t;

    // per-point sideband carried along the range and divide pipelines
    typedef struct packed {
        logic             pv;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } lane_t;

endpackage

@@ hdl/point_to_range_direction_top.sv @@
// Top level of the point-to-range-direction block
//
// Usage:
//   Configuration goes through the APB port (registers at byte addresses
//   0x00..0x1C: rot_w, rot_x, rot_y, rot_z, shift_x, shift_y, shift_z,
//   max_range). Write it only while no point is in flight.
//   A point word is taken at every clock edge where start is high and busy
//   is low; busy is always low, so one point can enter every cycle.
//   Each result word appears on range/dir_x/dir_y/dir_z for one cycle with
//   done high, in input order. Throughput is one point per cycle; the
//   latency is set by the transform, the 32-step square-root pipeline, the
//   16-step divider that forms the direction and the output register.
//   The receiver cannot stall; results must be captured when done is high.
//   Reset clears all in-flight points and loads the identity rotation,
//   zero translation and zero max_range.
//   An invalid point reports max_range + 1 (saturating) and zero direction.
`include "point_to_range_direction_top_macros.svh"
module point_to_range_direction_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [prd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    input  logic                       point_valid,
    output logic                       done,
    output logic [31:0]                range,
    output logic signed [15:0]         dir_x,
    output logic signed [15:0]         dir_y,
    output logic signed [15:0]         dir_z
);

    localparam int                 LATENCY = prd_pkg::LATENCY;
    localparam logic signed [15:0] DIR_MAX = prd_pkg::DIR_ONE;

    prd_pkg::cfg_t      cfg;
    logic               xf_valid;
    logic signed [31:0] xf_o [3];
    logic               xf_pv;
    logic               sq_valid;
    logic [31:0]        sq_r;
    prd_pkg::lane_t     sq_side;
    logic               dv_valid;
    logic [31:0]        dv_r;
    prd_pkg::lane_t     dv_side;
    logic [15:0]        dv_q [3];

    logic               done_reg;
    logic [31:0]        range_reg;
    logic [31:0]        range_next;
    logic signed [15:0] dir_reg  [3];
    logic signed [15:0] dir_next [3];

    assign busy = 1'b0;

    prd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prd_xf u_xf (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (start && !busy),
        .px        (point_x),
        .py        (point_y),
        .pz        (point_z),
        .pv        (point_valid),
        .out_valid (xf_valid),
        .o         (xf_o),
        .out_pv    (xf_pv)
    );

    prd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .o         (xf_o),
        .pv        (xf_pv),
        .out_valid (sq_valid),
        .r         (sq_r),
        .side      (sq_side)
    );

    prd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .r         (sq_r),
        .side      (sq_side),
        .out_valid (dv_valid),
        .r_out     (dv_r),
        .side_out  (dv_side),
        .q         (dv_q)
    );

    // final select: clamp, sign, invalid point and zero range
    always_comb
    begin
        logic [15:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_q[i] > prd_pkg::DIR_ONE) ? prd_pkg::DIR_ONE : dv_q[i];
            if (!dv_side.pv || dv_r == '0)
                dir_next[i] = '0;
            else if (dv_side.neg[i])
                dir_next[i] = -$signed(qc);
            else
                dir_next[i] = $signed(qc);
        end
        if (dv_side.pv)
            range_next = dv_r;
        else if (cfg.max_range == 32'hFFFFFFFF)
            range_next = cfg.max_range;
        else
            range_next = cfg.max_range + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        range_reg <= range_next;
        dir_reg   <= dir_next;
    end

    assign done  = done_reg;
    assign range = range_reg;
    assign dir_x = dir_reg[0];
    assign dir_y = dir_reg[1];
    assign dir_z = dir_reg[2];

    `PRD_ASSERT_IMPL(a_latency, clk, rst_n, start && !busy, ##LATENCY done)
    `PRD_ASSERT_IMPL(a_zero_range, clk, rst_n, done && range == '0, dir_x == '0 && dir_y == '0 && dir_z == '0)
    `PRD_ASSERT_IMPL(a_dir_bound, clk, rst_n, done, dir_x <= DIR_MAX && dir_x >= -DIR_MAX && dir_y <= DIR_MAX && dir_y >= -DIR_MAX && dir_z <= DIR_MAX && dir_z >= -DIR_MAX)

endmodule

@@ hdl/prd_cfg.sv @@
// APB register file holding the transform and range configuration
`include "point_to_range_direction_top_macros.svh"
module prd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output prd_pkg::cfg_t               cfg
);

    prd_pkg::cfg_t     cfg_reg;
    prd_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = prd_pkg::reg_idx_t'(paddr[prd_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes, truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_w     <= prd_pkg::ROT_W_RESET;
            cfg_reg.rot_x     <= '0;
            cfg_reg.rot_y     <= '0;
            cfg_reg.rot_z     <= '0;
            cfg_reg.shift_x   <= '0;
            cfg_reg.shift_y   <= '0;
            cfg_reg.shift_z   <= '0;
            cfg_reg.max_range <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                prd_pkg::REG_ROT_W:     cfg_reg.rot_w     <= pwdata[15:0];
                prd_pkg::REG_ROT_X:     cfg_reg.rot_x     <= pwdata[15:0];
                prd_pkg::REG_ROT_Y:     cfg_reg.rot_y     <= pwdata[15:0];
                prd_pkg::REG_ROT_Z:     cfg_reg.rot_z     <= pwdata[15:0];
                prd_pkg::REG_SHIFT_X:   cfg_reg.shift_x   <= pwdata;
                prd_pkg::REG_SHIFT_Y:   cfg_reg.shift_y   <= pwdata;
                prd_pkg::REG_SHIFT_Z:   cfg_reg.shift_z   <= pwdata;
                prd_pkg::REG_MAX_RANGE: cfg_reg.max_range <= pwdata;
                default:                cfg_reg.max_range <= cfg_reg.max_range;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            prd_pkg::REG_ROT_W:     prdata = {16'h0000, cfg_reg.rot_w};
            prd_pkg::REG_ROT_X:     prdata = {16'h0000, cfg_reg.rot_x};
            prd_pkg::REG_ROT_Y:     prdata = {16'h0000, cfg_reg.rot_y};
            prd_pkg::REG_ROT_Z:     prdata = {16'h0000, cfg_reg.rot_z};
            prd_pkg::REG_SHIFT_X:   prdata = cfg_reg.shift_x;
            prd_pkg::REG_SHIFT_Y:   prdata = cfg_reg.shift_y;
            prd_pkg::REG_SHIFT_Z:   prdata = cfg_reg.shift_z;
            prd_pkg::REG_MAX_RANGE: prdata = cfg_reg.max_range;
            default:                prdata = '0;
        endcase
    end

    `PRD_ASSERT_NEXT(a_max_wr, clk, rst_n, wr_en && idx == prd_pkg::REG_MAX_RANGE, cfg_reg.max_range == $past(pwdata))

endmodule

@@ hdl/prd_xf.sv @@
// Rigid transform pipeline: rotation matrix, products, sum, round, translate
module prd_xf (
    input  logic               clk,
    input  logic               rst_n,
    input  prd_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic               pv,
    output logic               out_valid,
    output logic signed [31:0] o [3],
    output logic               out_pv
);

    logic signed [33:0] mat_reg  [3][3];
    logic signed [33:0] mat_next [3][3];
    logic [4:0]         v_reg;
    logic [4:0]         pv_reg;

    logic signed [31:0] p_reg    [3];
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] prod_next[3][3];
    logic signed [63:0] acc_reg  [3];
    logic signed [63:0] acc_next [3];
    logic signed [37:0] rnd_reg  [3];
    logic signed [37:0] rnd_next [3];
    logic signed [31:0] o_reg    [3];
    logic signed [31:0] o_next   [3];
    logic signed [31:0] shift    [3];

    assign shift[0] = cfg.shift_x;
    assign shift[1] = cfg.shift_y;
    assign shift[2] = cfg.shift_z;

    // rotation matrix in Q.28 from the quaternion, refreshed every cycle
    always_comb
    begin
        logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        xx = cfg.rot_x * cfg.rot_x;
        yy = cfg.rot_y * cfg.rot_y;
        zz = cfg.rot_z * cfg.rot_z;
        xy = cfg.rot_x * cfg.rot_y;
        xz = cfg.rot_x * cfg.rot_z;
        yz = cfg.rot_y * cfg.rot_z;
        wx = cfg.rot_w * cfg.rot_x;
        wy = cfg.rot_w * cfg.rot_y;
        wz = cfg.rot_w * cfg.rot_z;
        mat_next[0][0] = 34'(prd_pkg::ONE_Q28 - ((35'(yy) + 35'(zz)) <<< 1));
        mat_next[0][1] = 34'((35'(xy) - 35'(wz)) <<< 1);
        mat_next[0][2] = 34'((35'(xz) + 35'(wy)) <<< 1);
        mat_next[1][0] = 34'((35'(xy) + 35'(wz)) <<< 1);
        mat_next[1][1] = 34'(prd_pkg::ONE_Q28 - ((35'(xx) + 35'(zz)) <<< 1));
        mat_next[1][2] = 34'((35'(yz) - 35'(wx)) <<< 1);
        mat_next[2][0] = 34'((35'(xz) - 35'(wy)) <<< 1);
        mat_next[2][1] = 34'((35'(yz) + 35'(wx)) <<< 1);
        mat_next[2][2] = 34'(prd_pkg::ONE_Q28 - ((35'(xx) + 35'(yy)) <<< 1));
    end

    // per-lane datapath: products, wrapped 64-bit sum, round, translate
    always_comb
    begin
        logic               neg;
        logic [63:0]        mag;
        logic [64:0]        rsum;
        logic signed [37:0] rmag;
        logic signed [38:0] s;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = 64'(66'(mat_reg[i][j]) * 66'(p_reg[j]));
            end
            acc_next[i] = prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
            neg  = acc_reg[i][63];
            mag  = neg ? 64'(-acc_reg[i]) : 64'(acc_reg[i]);
            rsum = {1'b0, mag} + prd_pkg::HALF_Q28;
            rmag = $signed({1'b0, rsum[64:28]});
            rnd_next[i] = neg ? -rmag : rmag;
            s = 39'(rnd_reg[i]) + 39'(shift[i]);
            if (s > 39'sd2147483647)
                o_next[i] = 32'sh7FFFFFFF;
            else if (s < -39'sd2147483648)
                o_next[i] = 32'sh80000000;
            else
                o_next[i] = 32'(s);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        mat_reg  <= mat_next;
        p_reg[0] <= px;
        p_reg[1] <= py;
        p_reg[2] <= pz;
        pv_reg   <= {pv_reg[3:0], pv};
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rnd_reg  <= rnd_next;
        o_reg    <= o_next;
    end

    assign out_valid = v_reg[4];
    assign out_pv    = pv_reg[4];
    assign o         = o_reg;

endmodule

@@ hdl/prd_sqrt.sv @@
// Range pipeline: squares, sum, one root bit per stage, round to nearest
module prd_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] o [3],
    input  logic               pv,
    output logic               out_valid,
    output logic [31:0]        r,
    output prd_pkg::lane_t     side
);

    localparam int STEPS = prd_pkg::SQRT_STEPS;
    localparam int REM_W = 34;

    // magnitudes and squares
    logic           a_v_reg;
    prd_pkg::lane_t a_side_reg;
    prd_pkg::lane_t a_side_next;
    logic [63:0]    sq_reg  [3];
    logic [63:0]    sq_next [3];
    logic [63:0]    sum_next;

    logic [REM_W-1:0] rem_reg  [STEPS+1];
    logic [31:0]      root_reg [STEPS+1];
    logic [63:0]      n_reg    [STEPS+1];
    prd_pkg::lane_t   side_reg [STEPS+1];
    logic             v_reg    [STEPS+1];

    logic             out_v_reg;
    logic [31:0]      r_reg;
    logic [31:0]      r_next;
    prd_pkg::lane_t   side_out_reg;

    always_comb
    begin
        logic [31:0] m;
        a_side_next.pv = pv;
        for (int i = 0; i < 3; i++)
        begin
            m = o[i][31] ? 32'(-33'(o[i])) : 32'(o[i]);
            a_side_next.neg[i] = o[i][31];
            a_side_next.mag[i] = m;
            sq_next[i] = 64'(m) * 64'(m);
        end
    end

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else
        begin
            a_v_reg  <= in_valid;
            v_reg[0] <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg  <= a_side_next;
        sq_reg      <= sq_next;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        n_reg[0]    <= sum_next;
        side_reg[0] <= a_side_reg;
    end

    // one result bit per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [REM_W+1:0] ext;
        logic [REM_W+1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [31:0]      root_next;

        always_comb
        begin
            ext       = {rem_reg[k], n_reg[k][63:62]};
            trial     = (REM_W+2)'({root_reg[k], 2'b01});
            ge        = ext >= trial;
            rem_next  = ge ? REM_W'(ext - trial) : REM_W'(ext);
            root_next = {root_reg[k][30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            n_reg[k+1]    <= n_reg[k] << 2;
            side_reg[k+1] <= side_reg[k];
        end
    end

    // round to nearest: bump when remainder exceeds the floor root
    always_comb
    begin
        logic        up;
        logic [32:0] r33;
        up     = rem_reg[STEPS] > REM_W'(root_reg[STEPS]);
        r33    = 33'(root_reg[STEPS]) + 33'(up);
        r_next = r33[32] ? 32'hFFFFFFFF : r33[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= v_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        side_out_reg <= side_reg[STEPS];
    end

    assign out_valid = out_v_reg;
    assign r         = r_reg;
    assign side      = side_out_reg;

endmodule

@@ hdl/prd_div.sv @@
// Direction divider: three lanes of restoring division, one quotient bit per stage
module prd_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [31:0]    r,
    input  prd_pkg::lane_t side,
    output logic           out_valid,
    output logic [31:0]    r_out,
    output prd_pkg::lane_t side_out,
    output logic [15:0]    q [3]
);

    localparam int STEPS = prd_pkg::DIV_STEPS;

    logic [32:0]    rem_reg  [STEPS+1][3];
    logic [15:0]    low_reg  [STEPS+1][3];
    logic [15:0]    q_reg    [STEPS+1][3];
    logic [32:0]    den_reg  [STEPS+1];
    logic [31:0]    r_reg    [STEPS+1];
    prd_pkg::lane_t side_reg [STEPS+1];
    logic           v_reg    [STEPS+1];

    logic [32:0]    rem0_next [3];
    logic [15:0]    low0_next [3];

    // numerator = mag * 2^15 + r, denominator = 2r; quotient fits 16 bits
    always_comb
    begin
        logic [47:0] num;
        for (int i = 0; i < 3; i++)
        begin
            num          = {1'b0, side.mag[i], 15'd0} + 48'(r);
            rem0_next[i] = 33'(num[47:16]);
            low0_next[i] = num[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i] <= rem0_next[i];
            low_reg[0][i] <= low0_next[i];
            q_reg[0][i]   <= '0;
        end
        den_reg[0]  <= {r, 1'b0};
        r_reg[0]    <= r;
        side_reg[0] <= side;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [32:0] rem_next [3];
        logic [15:0] q_next   [3];

        always_comb
        begin
            logic [33:0] ext;
            logic        ge;
            for (int i = 0; i < 3; i++)
            begin
                ext         = {rem_reg[k][i], low_reg[k][i][15]};
                ge          = ext >= {1'b0, den_reg[k]};
                rem_next[i] = ge ? 33'(ext - {1'b0, den_reg[k]}) : 33'(ext);
                q_next[i]   = {q_reg[k][i][14:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[k+1][i] <= rem_next[i];
                low_reg[k+1][i] <= low_reg[k][i] << 1;
                q_reg[k+1][i]   <= q_next[i];
            end
            den_reg[k+1]  <= den_reg[k];
            r_reg[k+1]    <= r_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[STEPS];
    assign r_out     = r_reg[STEPS];
    assign side_out  = side_reg[STEPS];
    assign q         = q_reg[STEPS];

endmodule
